// ===== hw/rtl/rsv_pkg.sv =====
// Shared types and constants of the route sample validator.
package rsv_pkg;

  // Field widths
  localparam int unsigned PosW   = 40;
  localparam int unsigned TanW   = 20;
  localparam int unsigned SpdW   = 32;
  localparam int unsigned IdxW   = 16;
  localparam int unsigned StatW  = 3;
  localparam int unsigned TolW   = 20;
  localparam int unsigned NtolW  = 16;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 20;

  // Arithmetic widths
  localparam int unsigned DeltaW = PosW + 1;
  localparam int unsigned OpW    = 22;
  localparam int unsigned ProdW  = 2 * OpW;
  localparam int unsigned AccW   = 84;
  localparam int unsigned RadW   = 82;
  localparam int unsigned RootW  = RadW / 2;
  localparam int unsigned RemW   = RootW + 3;
  localparam int unsigned StepW  = 5;
  localparam int unsigned IterW  = 6;

  // Multiply sequence: tangent norm and its bounds first, then the
  // segment length square and the two dot products.
  localparam logic [StepW-1:0] StepTanLast = 5'd4;
  localparam logic [StepW-1:0] StepLast    = 5'd25;
  localparam logic [IterW-1:0] SqrtLast    = IterW'(RootW - 1);

  // Result status codes
  localparam logic [StatW-1:0] StatValid    = 3'd0;
  localparam logic [StatW-1:0] StatTooFew   = 3'd1;
  localparam logic [StatW-1:0] StatBad      = 3'd2;
  localparam logic [StatW-1:0] StatTangent  = 3'd3;
  localparam logic [StatW-1:0] StatMono     = 3'd4;
  localparam logic [StatW-1:0] StatStation  = 3'd5;
  localparam logic [StatW-1:0] StatIncoming = 3'd6;
  localparam logic [StatW-1:0] StatTerminal = 3'd7;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgStationTol = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgMatchTol   = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgNormTol    = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgStopSpeed  = 8'd3;

  // Configuration reset values
  localparam logic [TolW-1:0]  RstStationTol = 20'd17;
  localparam logic [TolW-1:0]  RstMatchTol   = 20'd1678;
  localparam logic [NtolW-1:0] RstNormTol    = 16'd262;
  localparam logic [NtolW-1:0] RstStopSpeed  = 16'd0;

  localparam logic [IdxW-1:0] IdxCap = 16'hFFFF;
  localparam logic [OpW-1:0]  TanOne = 22'(1 << 18);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             in_ready;
    logic             eval;
    logic             mul_en;
    logic [StepW-1:0] step;
    logic             sqrt_init;
    logic             sqrt_step;
    logic             commit;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic too_few;
    logic latched;
    logic idx_zero;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/rsv_ctrl.sv =====
// Sequencing controller of the route sample validator.
module rsv_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  rsv_pkg::sts_t sts_i,
  output rsv_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    Idle, Eval, Mul, Drain, SqrtInit, Sqrt, Decide
  } state_e;

  state_e                        state_q;
  logic [rsv_pkg::StepW-1:0]     step_q;
  logic [rsv_pkg::IterW-1:0]     iter_q;

  // State, step and iteration counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      step_q  <= '0;
      iter_q  <= '0;
    end else begin
      case (state_q)
        Idle: begin
          if (in_valid_i) state_q <= Eval;
        end
        Eval: begin
          step_q <= '0;
          if (sts_i.too_few || sts_i.latched) state_q <= Decide;
          else state_q <= Mul;
        end
        Mul: begin
          if ((sts_i.idx_zero && step_q == rsv_pkg::StepTanLast) ||
              step_q == rsv_pkg::StepLast) begin
            state_q <= Drain;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        Drain: begin
          if (sts_i.idx_zero) state_q <= Decide;
          else state_q <= SqrtInit;
        end
        SqrtInit: begin
          iter_q  <= '0;
          state_q <= Sqrt;
        end
        Sqrt: begin
          if (iter_q == rsv_pkg::SqrtLast) state_q <= Decide;
          else iter_q <= iter_q + 1'b1;
        end
        Decide: begin
          if (sts_i.out_free) state_q <= Idle;
        end
        default: state_q <= Idle;
      endcase
    end
  end

  // Command decode
  always_comb begin
    cmd_o           = '0;
    cmd_o.step      = step_q;
    cmd_o.in_ready  = (state_q == Idle);
    cmd_o.eval      = (state_q == Eval);
    cmd_o.mul_en    = (state_q == Mul);
    cmd_o.sqrt_init = (state_q == SqrtInit);
    cmd_o.sqrt_step = (state_q == Sqrt);
    cmd_o.commit    = (state_q == Decide) && sts_i.out_free;
  end

endmodule

// ===== hw/rtl/rsv_datapath.sv =====
// Datapath of the route sample validator: sample registers, shared
// multiplier with accumulators, square root unit, checks and result register.
module rsv_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rsv_pkg::cmd_t                  cmd_i,
  output rsv_pkg::sts_t                  sts_o,
  input  logic                           in_valid_i,
  input  logic signed [rsv_pkg::PosW-1:0] pos_x_i,
  input  logic signed [rsv_pkg::PosW-1:0] pos_y_i,
  input  logic signed [rsv_pkg::PosW-1:0] pos_z_i,
  input  logic signed [rsv_pkg::TanW-1:0] tan_x_i,
  input  logic signed [rsv_pkg::TanW-1:0] tan_y_i,
  input  logic signed [rsv_pkg::TanW-1:0] tan_z_i,
  input  logic signed [rsv_pkg::PosW-1:0] station_i,
  input  logic signed [rsv_pkg::SpdW-1:0] speed_i,
  input  logic                           stop_and_turn_i,
  input  logic                           not_finite_i,
  input  logic                           first_sample_i,
  input  logic                           last_sample_i,
  input  logic                           cfg_valid_i,
  input  logic [rsv_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [rsv_pkg::CfgDataW-1:0]   cfg_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rsv_pkg::StatW-1:0]      res_status_o,
  output logic [rsv_pkg::IdxW-1:0]       res_index_o
);

  typedef enum logic [2:0] {
    GrpTan, GrpLob, GrpHib, GrpSeg, GrpDin, GrpDterm
  } grp_e;

  // Configuration registers
  logic [rsv_pkg::TolW-1:0]  station_tol_q, match_tol_q;
  logic [rsv_pkg::NtolW-1:0] norm_tol_q, stop_speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_tol_q <= rsv_pkg::RstStationTol;
      match_tol_q   <= rsv_pkg::RstMatchTol;
      norm_tol_q    <= rsv_pkg::RstNormTol;
      stop_speed_q  <= rsv_pkg::RstStopSpeed;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rsv_pkg::CfgStationTol: station_tol_q <= cfg_data_i;
        rsv_pkg::CfgMatchTol:   match_tol_q   <= cfg_data_i;
        rsv_pkg::CfgNormTol:    norm_tol_q    <= cfg_data_i[rsv_pkg::NtolW-1:0];
        rsv_pkg::CfgStopSpeed:  stop_speed_q  <= cfg_data_i[rsv_pkg::NtolW-1:0];
        default: ;
      endcase
    end
  end

  // Sample registers, captured on an input transaction
  logic signed [rsv_pkg::PosW-1:0] pos_q [3];
  logic signed [rsv_pkg::TanW-1:0] tan_q [3];
  logic signed [rsv_pkg::PosW-1:0] sta_q;
  logic signed [rsv_pkg::SpdW-1:0] spd_q;
  logic                            stop_q, nonfin_q, last_q;
  logic [rsv_pkg::IdxW-1:0]        idx_q;

  // Route state
  logic signed [rsv_pkg::PosW-1:0] prev_pos_q [3];
  logic signed [rsv_pkg::TanW-1:0] prev_tan_q [3];
  logic signed [rsv_pkg::PosW-1:0] prev_sta_q;
  logic [rsv_pkg::IdxW-1:0]        count_q;
  logic                            latched_q;
  logic [rsv_pkg::StatW-1:0]       lstat_q;
  logic [rsv_pkg::IdxW-1:0]        lidx_q;

  // Output register
  logic                            out_valid_q;
  logic [rsv_pkg::StatW-1:0]       out_stat_q;
  logic [rsv_pkg::IdxW-1:0]        out_idx_q;

  logic in_accept;
  logic [rsv_pkg::IdxW-1:0] idx_new;
  logic too_few;

  assign in_accept = in_valid_i && cmd_i.in_ready;
  assign idx_new   = first_sample_i ? '0 : count_q;
  assign too_few   = last_q && (idx_q == '0);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pos_q[0] <= pos_x_i;
      pos_q[1] <= pos_y_i;
      pos_q[2] <= pos_z_i;
      tan_q[0] <= tan_x_i;
      tan_q[1] <= tan_y_i;
      tan_q[2] <= tan_z_i;
      sta_q    <= station_i;
      spd_q    <= speed_i;
      stop_q   <= stop_and_turn_i;
      nonfin_q <= not_finite_i;
      last_q   <= last_sample_i;
      idx_q    <= idx_new;
    end
  end

  // Position deltas against the previous sample
  logic signed [rsv_pkg::DeltaW-1:0] d_q [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      for (int c = 0; c < 3; c++) begin
        d_q[c] <= rsv_pkg::DeltaW'(pos_q[c]) - rsv_pkg::DeltaW'(prev_pos_q[c]);
      end
    end
  end

  // Decode of the multiply step into group, axis and part
  grp_e     grp;
  logic [1:0] axis, part;
  logic       first_op;
  logic [rsv_pkg::StepW-1:0] t;

  always_comb begin
    grp      = GrpTan;
    axis     = '0;
    part     = '0;
    first_op = 1'b0;
    t        = '0;
    if (cmd_i.step < 5'd3) begin
      grp      = GrpTan;
      axis     = cmd_i.step[1:0];
      first_op = (cmd_i.step == '0);
    end else if (cmd_i.step == 5'd3) begin
      grp      = GrpLob;
      first_op = 1'b1;
    end else if (cmd_i.step == 5'd4) begin
      grp      = GrpHib;
      first_op = 1'b1;
    end else if (cmd_i.step < 5'd14) begin
      grp      = GrpSeg;
      t        = cmd_i.step - 5'd5;
      if (t >= 5'd6) begin
        axis = 2'd2;
        part = 2'(t - 5'd6);
      end else if (t >= 5'd3) begin
        axis = 2'd1;
        part = 2'(t - 5'd3);
      end else begin
        axis = 2'd0;
        part = t[1:0];
      end
      first_op = (t == '0);
    end else if (cmd_i.step < 5'd20) begin
      grp      = GrpDin;
      t        = cmd_i.step - 5'd14;
      axis     = t[2:1];
      part     = {1'b0, t[0]};
      first_op = (t == '0);
    end else begin
      grp      = GrpDterm;
      t        = cmd_i.step - 5'd20;
      axis     = t[2:1];
      part     = {1'b0, t[0]};
      first_op = (t == '0);
    end
  end

  // Operand selection for the shared multiplier
  logic signed [rsv_pkg::TanW-1:0]   tan_sel, ptan_sel;
  logic signed [rsv_pkg::DeltaW-1:0] d_sel;
  logic signed [rsv_pkg::OpW-1:0]    dl_op, dh_op, op_a, op_b;
  logic [5:0]                        shift;

  always_comb begin
    case (axis)
      2'd1: begin
        tan_sel  = tan_q[1];
        ptan_sel = prev_tan_q[1];
        d_sel    = d_q[1];
      end
      2'd2: begin
        tan_sel  = tan_q[2];
        ptan_sel = prev_tan_q[2];
        d_sel    = d_q[2];
      end
      default: begin
        tan_sel  = tan_q[0];
        ptan_sel = prev_tan_q[0];
        d_sel    = d_q[0];
      end
    endcase
  end

  // The low half is unsigned and the high half carries the sign of the delta.
  assign dl_op = $signed({1'b0, d_sel[20:0]});
  assign dh_op = rsv_pkg::OpW'($signed(d_sel[rsv_pkg::DeltaW-1:21]));

  always_comb begin
    op_a  = '0;
    op_b  = '0;
    shift = 6'd0;
    case (grp)
      GrpTan: begin
        op_a = rsv_pkg::OpW'(tan_sel);
        op_b = rsv_pkg::OpW'(tan_sel);
      end
      GrpLob: begin
        op_a = rsv_pkg::TanOne - rsv_pkg::OpW'(norm_tol_q);
        op_b = rsv_pkg::TanOne - rsv_pkg::OpW'(norm_tol_q);
      end
      GrpHib: begin
        op_a = rsv_pkg::TanOne + rsv_pkg::OpW'(norm_tol_q);
        op_b = rsv_pkg::TanOne + rsv_pkg::OpW'(norm_tol_q);
      end
      GrpSeg: begin
        case (part)
          2'd0: begin
            op_a = dl_op;
            op_b = dl_op;
          end
          2'd1: begin
            op_a  = dh_op;
            op_b  = dl_op;
            shift = 6'd22;
          end
          default: begin
            op_a  = dh_op;
            op_b  = dh_op;
            shift = 6'd42;
          end
        endcase
      end
      GrpDin: begin
        op_a  = rsv_pkg::OpW'(ptan_sel);
        op_b  = part[0] ? dh_op : dl_op;
        shift = part[0] ? 6'd21 : 6'd0;
      end
      GrpDterm: begin
        op_a  = rsv_pkg::OpW'(tan_sel);
        op_b  = part[0] ? dh_op : dl_op;
        shift = part[0] ? 6'd21 : 6'd0;
      end
      default: ;
    endcase
  end

  // Multiplier stage
  logic signed [rsv_pkg::ProdW-1:0] prod_q;
  logic [5:0]                       shift_q;
  grp_e                             dest_q;
  logic                             first_q, pvalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= 1'b0;
    end else begin
      pvalid_q <= cmd_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q  <= op_a * op_b;
      shift_q <= shift;
      dest_q  <= grp;
      first_q <= first_op;
    end
  end

  // Accumulate stage: one adder shared by all sums
  logic signed [rsv_pkg::AccW-1:0] n2_q, lob_q, hib_q, s_q, din_q, dterm_q;
  logic signed [rsv_pkg::AccW-1:0] acc_base, acc_sum;

  always_comb begin
    case (dest_q)
      GrpTan:   acc_base = n2_q;
      GrpLob:   acc_base = lob_q;
      GrpHib:   acc_base = hib_q;
      GrpSeg:   acc_base = s_q;
      GrpDin:   acc_base = din_q;
      GrpDterm: acc_base = dterm_q;
      default:  acc_base = '0;
    endcase
    if (first_q) acc_base = '0;
    acc_sum = acc_base + (rsv_pkg::AccW'(prod_q) <<< shift_q);
  end

  always_ff @(posedge clk_i) begin
    if (pvalid_q) begin
      case (dest_q)
        GrpTan:   n2_q    <= acc_sum;
        GrpLob:   lob_q   <= acc_sum;
        GrpHib:   hib_q   <= acc_sum;
        GrpSeg:   s_q     <= acc_sum;
        GrpDin:   din_q   <= acc_sum;
        GrpDterm: dterm_q <= acc_sum;
        default: ;
      endcase
    end
  end

  // Square root unit: two radicand bits per cycle
  logic [rsv_pkg::RadW-1:0]  rad_q;
  logic [rsv_pkg::RemW-1:0]  rem_q, rem_t, trial;
  logic [rsv_pkg::RootW-1:0] root_q;

  assign rem_t = {rem_q[rsv_pkg::RemW-3:0], rad_q[rsv_pkg::RadW-1 -: 2]};
  assign trial = rsv_pkg::RemW'({root_q, 2'b01});

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      rad_q  <= s_q[rsv_pkg::RadW-1:0];
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q <= {rad_q[rsv_pkg::RadW-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem_q  <= rem_t - trial;
        root_q <= {root_q[rsv_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_t;
        root_q <= {root_q[rsv_pkg::RootW-2:0], 1'b0};
      end
    end
  end

  // Checks in priority order
  logic signed [rsv_pkg::DeltaW-1:0] sdelta;
  logic signed [rsv_pkg::DeltaW+1:0] diff;
  logic [rsv_pkg::DeltaW+1:0]        diff_mag;
  logic bad, tan_bad, len_bad;
  logic [rsv_pkg::StatW-1:0] st;

  always_comb begin
    sdelta   = rsv_pkg::DeltaW'(sta_q) - rsv_pkg::DeltaW'(prev_sta_q);
    diff     = (rsv_pkg::DeltaW+2)'(sdelta) - $signed({2'b00, root_q});
    diff_mag = diff[rsv_pkg::DeltaW+1] ? (rsv_pkg::DeltaW+2)'(-diff)
                                       : (rsv_pkg::DeltaW+2)'(diff);
    bad      = nonfin_q || sta_q[rsv_pkg::PosW-1] || spd_q[rsv_pkg::SpdW-1] ||
               (stop_q && (spd_q[rsv_pkg::SpdW-2:0] >
                           (rsv_pkg::SpdW-1)'(stop_speed_q)));
    tan_bad  = (n2_q[40:0] < lob_q[40:0]) || (n2_q[40:0] > hib_q[40:0]);
    len_bad  = (root_q <= rsv_pkg::RootW'(station_tol_q)) ||
               (diff_mag > (rsv_pkg::DeltaW+2)'(match_tol_q));
    if (bad) begin
      st = rsv_pkg::StatBad;
    end else if (tan_bad) begin
      st = rsv_pkg::StatTangent;
    end else if (idx_q == '0) begin
      st = (sta_q[rsv_pkg::PosW-2:0] > (rsv_pkg::PosW-1)'(station_tol_q)) ?
           rsv_pkg::StatStation : rsv_pkg::StatValid;
    end else if (sta_q <= prev_sta_q) begin
      st = rsv_pkg::StatMono;
    end else if (len_bad) begin
      st = rsv_pkg::StatStation;
    end else if (din_q[rsv_pkg::AccW-1] || din_q == '0) begin
      st = rsv_pkg::StatIncoming;
    end else if (last_q && (dterm_q[rsv_pkg::AccW-1] || dterm_q == '0)) begin
      st = rsv_pkg::StatTerminal;
    end else begin
      st = rsv_pkg::StatValid;
    end
  end

  // Route state update and result capture
  logic fail;
  logic latched_n;
  logic [rsv_pkg::StatW-1:0] lstat_n;
  logic [rsv_pkg::IdxW-1:0]  lidx_n;

  always_comb begin
    fail      = !latched_q && !too_few && (st != rsv_pkg::StatValid);
    latched_n = latched_q || fail;
    lstat_n   = fail ? st : lstat_q;
    lidx_n    = fail ? idx_q : lidx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      latched_q   <= 1'b0;
      lstat_q     <= '0;
      lidx_q      <= '0;
      out_valid_q <= 1'b0;
      prev_sta_q  <= '0;
      for (int c = 0; c < 3; c++) begin
        prev_pos_q[c] <= '0;
        prev_tan_q[c] <= '0;
      end
    end else begin
      // A new result replaces one that leaves in the same cycle.
      if (cmd_i.commit && last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_accept && (idx_new == '0)) begin
        latched_q <= 1'b0;
        lstat_q   <= '0;
        lidx_q    <= '0;
      end
      if (cmd_i.commit) begin
        if (!too_few) begin
          prev_sta_q <= sta_q;
          for (int c = 0; c < 3; c++) begin
            prev_pos_q[c] <= pos_q[c];
            prev_tan_q[c] <= tan_q[c];
          end
        end
        if (last_q) begin
          count_q     <= '0;
          latched_q   <= 1'b0;
          lstat_q     <= '0;
          lidx_q      <= '0;
        end else begin
          count_q   <= (idx_q < rsv_pkg::IdxCap) ? idx_q + 1'b1 : rsv_pkg::IdxCap;
          latched_q <= latched_n;
          lstat_q   <= lstat_n;
          lidx_q    <= lidx_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && last_q) begin
      if (too_few) begin
        out_stat_q <= rsv_pkg::StatTooFew;
        out_idx_q  <= rsv_pkg::IdxW'(1);
      end else if (latched_n) begin
        out_stat_q <= lstat_n;
        out_idx_q  <= lidx_n;
      end else begin
        out_stat_q <= rsv_pkg::StatValid;
        out_idx_q  <= idx_q;
      end
    end
  end

  // Status to the controller and output ports
  always_comb begin
    sts_o.too_few  = too_few;
    sts_o.latched  = latched_q;
    sts_o.idx_zero = (idx_q == '0);
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign res_status_o = out_stat_q;
  assign res_index_o  = out_idx_q;

endmodule

// ===== hw/rtl/route_sample_validator_top.sv =====
// Top level of the route sample validator.
//
// Route samples arrive one per transaction on the input channel (valid and
// ready). Each sample is checked for sanity, tangent length, rising station,
// agreement of station with the segment length and tangent direction. The
// first failure of a route and its sample index are held; one result
// transaction leaves on the output channel at the sample marked last.
// A fully checked sample runs 26 steps of the shared 22x22 multiplier and
// 41 steps of the two-bit-per-cycle square root before its commit. A first
// sample runs only the tangent steps, and a sample after a failure or a lone
// last sample goes from evaluation straight to commit. One sample is in
// flight at a time: a new sample is accepted only once the last one commits.
// A finished result waits in the output register; the next sample is
// accepted while it waits, but that sample holds in its commit step until
// the receiver takes the earlier result.
// Configuration transactions are always accepted and are meant to be made
// while the block is idle. Reset clears the route state and restores the
// register defaults.
module route_sample_validator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [rsv_pkg::PosW-1:0] pos_x_i,
  input  logic signed [rsv_pkg::PosW-1:0] pos_y_i,
  input  logic signed [rsv_pkg::PosW-1:0] pos_z_i,
  input  logic signed [rsv_pkg::TanW-1:0] tan_x_i,
  input  logic signed [rsv_pkg::TanW-1:0] tan_y_i,
  input  logic signed [rsv_pkg::TanW-1:0] tan_z_i,
  input  logic signed [rsv_pkg::PosW-1:0] station_i,
  input  logic signed [rsv_pkg::SpdW-1:0] speed_i,
  input  logic                            stop_and_turn_i,
  input  logic                            not_finite_i,
  input  logic                            first_sample_i,
  input  logic                            last_sample_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rsv_pkg::StatW-1:0]       status_o,
  output logic [rsv_pkg::IdxW-1:0]        sample_index_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rsv_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [rsv_pkg::CfgDataW-1:0]    cfg_data_i
);

  rsv_pkg::cmd_t cmd;
  rsv_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = cmd.in_ready;

  // Sequencer
  rsv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Arithmetic and route state
  rsv_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_valid_i      (in_valid_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pos_z_i         (pos_z_i),
    .tan_x_i         (tan_x_i),
    .tan_y_i         (tan_y_i),
    .tan_z_i         (tan_z_i),
    .station_i       (station_i),
    .speed_i         (speed_i),
    .stop_and_turn_i (stop_and_turn_i),
    .not_finite_i    (not_finite_i),
    .first_sample_i  (first_sample_i),
    .last_sample_i   (last_sample_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .res_status_o    (status_o),
    .res_index_o     (sample_index_o)
  );

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench of the route sample validator.
`timescale 1ns / 1ps

module testbench;
  import rsv_pkg::*;

  // One route sample as driven on the input channel.
  typedef struct {
    logic signed [PosW-1:0] px, py, pz;
    logic signed [TanW-1:0] tx, ty, tz;
    logic signed [PosW-1:0] sta;
    logic signed [SpdW-1:0] spd;
    logic                   stop, nonfin, first, last;
    bit                     drain;
  } sample_t;

  typedef struct {
    logic [StatW-1:0] status;
    logic [IdxW-1:0]  index;
  } verdict_t;

  localparam longint TanUnit = 64'sd262144;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Channel signals.
  logic                  in_valid = 1'b0;
  logic                  in_ready_o;
  sample_t               cur = '{default: 0};
  logic                  out_valid_o;
  logic                  out_ready = 1'b0;
  logic [StatW-1:0]      status_o;
  logic [IdxW-1:0]       sample_index_o;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index = '0;
  logic [CfgDataW-1:0]   cfg_data = '0;

  // Bench bookkeeping.
  sample_t  send_q[$];
  verdict_t verdict_q[$];
  bit       in_taken, cfg_taken;
  bit       stall_on = 1'b1;
  bit       route_open;
  int       err_count, n_queued, n_samples, n_verdicts;
  int       status_seen[8];

  // Register shadow used by the predictor.
  logic [TolW-1:0]  station_tol;
  logic [TolW-1:0]  match_tol;
  logic [NtolW-1:0] norm_tol;
  logic [NtolW-1:0] stop_limit;

  // Route state of the predictor.
  longint      last_sta, last_pos[3], last_tan[3];
  int unsigned route_idx;
  bit          fail_held;
  logic [StatW-1:0] held_status;
  logic [IdxW-1:0]  held_idx;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  route_sample_validator_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .pos_x_i        (cur.px),
    .pos_y_i        (cur.py),
    .pos_z_i        (cur.pz),
    .tan_x_i        (cur.tx),
    .tan_y_i        (cur.ty),
    .tan_z_i        (cur.tz),
    .station_i      (cur.sta),
    .speed_i        (cur.spd),
    .stop_and_turn_i(cur.stop),
    .not_finite_i   (cur.nonfin),
    .first_sample_i (cur.first),
    .last_sample_i  (cur.last),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .status_o       (status_o),
    .sample_index_o (sample_index_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // Exact floor of the Euclidean length of a position delta.
  function automatic longint seg_len(longint dx, longint dy, longint dz);
    logic [127:0] acc, sq;
    logic [63:0]  mu, r, c;
    longint       d[3];
    d[0] = dx;
    d[1] = dy;
    d[2] = dz;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      mu = (d[i] < 0) ? 64'(-d[i]) : 64'(d[i]);
      acc += {64'd0, mu} * {64'd0, mu};
    end
    r = '0;
    for (int b = 42; b >= 0; b--) begin
      c = r | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= acc) r = c;
    end
    return longint'(r);
  endfunction

  // Checks of one sample in their fixed order; the first failing one wins.
  function automatic logic [StatW-1:0] judge(int unsigned idx, sample_t s);
    longint t[3], d[3], sta, len, diff, n2, lo_b, hi_b;
    sta = s.sta;
    t[0] = s.tx;
    t[1] = s.ty;
    t[2] = s.tz;
    if (s.nonfin || sta < 0 || s.spd < 0 ||
        (s.stop && longint'(s.spd) > longint'(stop_limit))) return StatBad;
    n2 = t[0] * t[0] + t[1] * t[1] + t[2] * t[2];
    lo_b = (TanUnit - longint'(norm_tol)) * (TanUnit - longint'(norm_tol));
    hi_b = (TanUnit + longint'(norm_tol)) * (TanUnit + longint'(norm_tol));
    if (n2 < lo_b || n2 > hi_b) return StatTangent;
    if (idx == 0) begin
      if (sta > longint'(station_tol)) return StatStation;
      return StatValid;
    end
    if (sta <= last_sta) return StatMono;
    d[0] = longint'(s.px) - last_pos[0];
    d[1] = longint'(s.py) - last_pos[1];
    d[2] = longint'(s.pz) - last_pos[2];
    len = seg_len(d[0], d[1], d[2]);
    diff = (sta - last_sta) - len;
    if (diff < 0) diff = -diff;
    if (len <= longint'(station_tol) || diff > longint'(match_tol)) return StatStation;
    if (last_tan[0] * d[0] + last_tan[1] * d[1] + last_tan[2] * d[2] <= 0)
      return StatIncoming;
    if (s.last && t[0] * d[0] + t[1] * d[1] + t[2] * d[2] <= 0) return StatTerminal;
    return StatValid;
  endfunction

  // Advance the predicted route state by one accepted sample.
  task automatic predict_sample(sample_t s);
    int unsigned      idx;
    logic [StatW-1:0] st;
    if (s.first) route_idx = 0;
    if (route_idx == 0) begin
      fail_held = 1'b0;
      held_status = StatValid;
      held_idx = '0;
    end
    idx = route_idx;
    if (s.last && idx == 0) begin
      verdict_q.push_back('{StatTooFew, 16'd1});
      route_idx = 0;
    end else begin
      if (!fail_held) begin
        st = judge(idx, s);
        if (st != StatValid) begin
          fail_held = 1'b1;
          held_status = st;
          held_idx = idx[IdxW-1:0];
        end
      end
      last_sta = s.sta;
      last_pos[0] = s.px;
      last_pos[1] = s.py;
      last_pos[2] = s.pz;
      last_tan[0] = s.tx;
      last_tan[1] = s.ty;
      last_tan[2] = s.tz;
      route_idx = (idx < int'(IdxCap)) ? idx + 1 : idx;
      if (s.last) begin
        if (fail_held) verdict_q.push_back('{held_status, held_idx});
        else verdict_q.push_back('{StatValid, idx[IdxW-1:0]});
        route_idx = 0;
        fail_held = 1'b0;
      end
    end
  endtask

  // Input driver: presents queued samples at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      if (send_q.size() != 0 && !(send_q[0].drain && verdict_q.size() != 0) &&
          !(stall_on && $urandom_range(0, 99) < 26)) begin
        cur <= send_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver stalls at random.
  always @(negedge clk_i) begin
    out_ready <= !stall_on || ($urandom_range(0, 99) >= 26);
  end

  // Monitor: records transactions at the rising edge and checks results.
  always @(posedge clk_i) begin
    verdict_t want;
    in_taken = rst_ni && in_valid && in_ready_o;
    cfg_taken = rst_ni && cfg_valid && cfg_ready_o;
    if (in_taken) begin
      predict_sample(cur);
      n_samples++;
    end
    if (cfg_taken) begin
      case (cfg_index)
        CfgStationTol: station_tol = cfg_data[TolW-1:0];
        CfgMatchTol:   match_tol = cfg_data[TolW-1:0];
        CfgNormTol:    norm_tol = cfg_data[NtolW-1:0];
        CfgStopSpeed:  stop_limit = cfg_data[NtolW-1:0];
        default: ;
      endcase
    end
    if (rst_ni && out_valid_o && out_ready) begin
      n_verdicts++;
      status_seen[status_o]++;
      if (verdict_q.size() == 0) begin
        $error("unexpected result: status %0d index %0d", status_o, sample_index_o);
        err_count++;
      end else begin
        want = verdict_q.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          err_count++;
        end
        if (sample_index_o !== want.index) begin
          $error("sample_index: expected %0d, got %0d", want.index, sample_index_o);
          err_count++;
        end
      end
    end
  end

  // One register write transaction.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  // Wait until all samples are taken and all results are in, then let the
  // block finish any sample that gives no result.
  task automatic settle();
    while (send_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // Queue one route; fault selects an injected defect, -1 for none.
  task automatic add_route(int n, int fault, bit finish, bit drain);
    sample_t s[];
    longint  len[];
    longint  p[3], d[3];
    int      axis, sgn, j;
    s = new[n];
    len = new[n];
    axis = $urandom_range(0, 2);
    sgn = $urandom_range(0, 1) ? 1 : -1;
    for (int i = 0; i < 3; i++) p[i] = longint'($urandom_range(0, 32'h7fff_ffff)) - 2 ** 30;
    for (int k = 0; k < n; k++) begin
      s[k] = '{default: 0};
      if (k == 0) begin
        s[k].sta = $urandom_range(0, int'(station_tol));
        len[k] = 0;
      end else begin
        for (int i = 0; i < 3; i++) d[i] = longint'($urandom_range(0, 2046)) - 1023;
        d[axis] = sgn * (longint'(station_tol) + 1 + longint'($urandom_range(0, 2 ** 28)));
        for (int i = 0; i < 3; i++) p[i] += d[i];
        len[k] = seg_len(d[0], d[1], d[2]);
        d[0] = longint'($urandom_range(0, int'(match_tol))) *
               ($urandom_range(0, 1) ? 1 : -1);
        if (d[0] <= -len[k]) d[0] = 0;
        s[k].sta = longint'(s[k-1].sta) + len[k] + d[0];
      end
      s[k].px = p[0];
      s[k].py = p[1];
      s[k].pz = p[2];
      case (axis)
        0: s[k].tx = sgn * TanUnit;
        1: s[k].ty = sgn * TanUnit;
        default: s[k].tz = sgn * TanUnit;
      endcase
      s[k].stop = ($urandom_range(0, 4) == 0);
      s[k].spd = s[k].stop ? $urandom_range(0, int'(stop_limit)) : $urandom_range(0, 32'h7fff_ffff);
    end
    // Defects that need a previous sample are dropped on a one-sample route.
    if (n < 2 && fault >= 5 && fault <= 8) fault = -1;
    // Place the injected defect on a sample where it is the first to trip.
    if (fault >= 5 && fault <= 8) j = $urandom_range(1, n - 1);
    else if (fault == 9) j = n - 1;
    else if (fault == 10) j = 0;
    else j = $urandom_range(0, n - 1);
    case (fault)
      0: s[j].nonfin = 1'b1;
      1: s[j].sta = -(longint'($urandom_range(1, 32'h7fff_ffff)));
      2: s[j].spd = -(longint'($urandom_range(1, 32'h7fff_ffff)));
      3: begin
        s[j].stop = 1'b1;
        s[j].spd = longint'(stop_limit) + 1 + $urandom_range(0, 1000);
      end
      4: begin
        d[0] = $urandom_range(0, 1) ? TanUnit + longint'(norm_tol) + 1 + $urandom_range(0, 99)
                                    : TanUnit - longint'(norm_tol) - 1 - $urandom_range(0, 99);
        if (axis == 0) s[j].tx = sgn * d[0];
        else if (axis == 1) s[j].ty = sgn * d[0];
        else s[j].tz = sgn * d[0];
      end
      5: s[j].sta = s[j-1].sta;
      6: s[j].sta = longint'(s[j-1].sta) + len[j] + longint'(match_tol) + 1 +
                    $urandom_range(0, 999);
      7: begin
        s[j].px = s[j-1].px;
        s[j].py = s[j-1].py;
        s[j].pz = s[j-1].pz;
        s[j].sta = longint'(s[j-1].sta) + 1;
      end
      8: begin
        s[j-1].tx = -s[j-1].tx;
        s[j-1].ty = -s[j-1].ty;
        s[j-1].tz = -s[j-1].tz;
      end
      9: begin
        s[j].tx = -s[j].tx;
        s[j].ty = -s[j].ty;
        s[j].tz = -s[j].tz;
      end
      10: s[j].sta = longint'(station_tol) + 1 + $urandom_range(0, 999);
      default: ;
    endcase
    s[0].first = route_open || ($urandom_range(0, 9) != 0);
    s[0].drain = drain;
    s[n-1].last = finish;
    route_open = !finish;
    foreach (s[k]) send_q.push_back(s[k]);
    n_queued += n;
  endtask

  // One sample with every input field random.
  task automatic add_noise();
    sample_t s;
    s.px = PosW'({$urandom, $urandom});
    s.py = PosW'({$urandom, $urandom});
    s.pz = PosW'({$urandom, $urandom});
    s.tx = TanW'($urandom);
    s.ty = TanW'($urandom);
    s.tz = TanW'($urandom);
    s.sta = PosW'({$urandom, $urandom});
    s.spd = $urandom;
    s.stop = $urandom_range(0, 1);
    s.nonfin = ($urandom_range(0, 3) == 0);
    s.first = $urandom_range(0, 1);
    s.last = ($urandom_range(0, 2) == 0);
    s.drain = 1'b0;
    route_open = !s.last;
    send_q.push_back(s);
    n_queued++;
  endtask

  // Write all registers, then run random routes and noise.
  task automatic run_phase(int stol, int mtol, int ntol, int slim, int items, bit quiet);
    int stop_at;
    settle();
    write_reg(CfgStationTol, CfgDataW'(stol));
    write_reg(CfgMatchTol, CfgDataW'(mtol));
    write_reg(CfgNormTol, CfgDataW'(ntol));
    write_reg(CfgStopSpeed, CfgDataW'(slim));
    stall_on = !quiet;
    stop_at = n_queued + items;
    while (n_queued < stop_at) begin
      if ($urandom_range(0, 99) < 15) add_noise();
      else add_route($urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 8),
                     $urandom_range(0, 99) < 40 ? $urandom_range(0, 10) : -1,
                     $urandom_range(0, 9) != 0, $urandom_range(0, 19) == 0);
    end
  endtask

  initial begin
    sample_t ext;
    station_tol = RstStationTol;
    match_tol = RstMatchTol;
    norm_tol = RstNormTol;
    stop_limit = RstStopSpeed;
    route_idx = 0;
    fail_held = 1'b0;
    last_sta = 0;
    for (int i = 0; i < 3; i++) begin
      last_pos[i] = 0;
      last_tan[i] = 0;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at reset settings: a clean route, every defect once,
    // a lone last sample and samples at the field extremes.
    add_route(3, -1, 1'b1, 1'b0);
    for (int f = 0; f <= 10; f++) add_route(2, f, 1'b1, f == 5);
    ext = '{px: {1'b0, {PosW-1{1'b1}}}, py: {1'b1, {PosW-1{1'b0}}}, pz: '1,
            tx: {1'b0, {TanW-1{1'b1}}}, ty: {1'b1, {TanW-1{1'b0}}}, tz: '0,
            sta: {1'b0, {PosW-1{1'b1}}}, spd: {1'b1, {SpdW-1{1'b0}}},
            stop: 1'b1, nonfin: 1'b0, first: 1'b1, last: 1'b0, drain: 1'b1};
    send_q.push_back(ext);
    ext = '{px: {1'b1, {PosW-1{1'b0}}}, py: {1'b0, {PosW-1{1'b1}}}, pz: '0,
            tx: {1'b1, {TanW-1{1'b0}}}, ty: '1, tz: {1'b0, {TanW-1{1'b1}}},
            sta: '1, spd: {1'b0, {SpdW-1{1'b1}}},
            stop: 1'b0, nonfin: 1'b1, first: 1'b0, last: 1'b1, drain: 1'b0};
    send_q.push_back(ext);
    ext.first = 1'b1;
    send_q.push_back(ext);
    n_queued += 3;
    route_open = 1'b0;

    run_phase(0, 0, 0, 0, 150, 1'b1);
    run_phase(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 150, 1'b0);
    run_phase($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
              $urandom_range(0, 65535), 200, 1'b0);
    run_phase(RstStationTol, RstMatchTol, RstNormTol, RstStopSpeed, 170, 1'b0);
    settle();

    $display("Checked %0d samples and %0d route results over five register settings.",
             n_samples, n_verdicts);
    $display("Results by status 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
    if (err_count == 0 && verdict_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
